// ===== hw/rtl/assert_macros.svh =====
// assertion helpers included by the top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define MCLM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lock manager assertion failed");

// expression must never be true out of reset
`define MCLM_NEVER(name, expr) \
  `MCLM_ASSERT(name, !(expr))

`endif

// ===== hw/rtl/mclm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mclm_pkg
// Types, request codes and datapath commands of the mutex and condition
// variable lock manager.
// ----------------------------------------------------------------------------
package mclm_pkg;

  localparam int MODE_W = 3;
  localparam int PROC_W = 8;
  localparam int KEY_W  = 32;
  localparam int ST_W   = 2;

  localparam logic [MODE_W-1:0] MODE_LOCK    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_UNLOCK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WAIT    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BCAST   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_UNPAUSE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_EXIT    = 3'd5;

  localparam logic [ST_W-1:0] ST_OK         = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_WAIT   = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_UNLOCK = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_HSCAN_INIT, OP_HRD, OP_HCHK, OP_XCHK,
    OP_HRD_LAST, OP_H_MOVE, OP_H_APPEND, OP_H_APPEND_G, OP_REL_START,
    OP_LW_APPEND, OP_LC_INIT, OP_LRD, OP_LCHK, OP_LC_END,
    OP_CW_APPEND, OP_CC_INIT, OP_CRD, OP_CCHK, OP_CKEEP, OP_CDROP,
    OP_CC_END, OP_ALOAD_CW, OP_EMIT, OP_FLUSH
  } dp_op_e;

  typedef enum logic [1:0] {TGT_REQ, TGT_ACQ, TGT_GRANT} tgt_sel_e;

  typedef enum logic [1:0] {
    SCAN_KEY_FIRST, SCAN_PROC_FIRST, SCAN_PROC_ALL
  } scan_mode_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [PROC_W-1:0] own;
  } ent_t;

  typedef struct packed {
    logic [KEY_W-1:0]  cond;
    logic [PROC_W-1:0] proc;
    logic [KEY_W-1:0]  mut;
  } cw_ent_t;

  typedef struct packed {
    dp_op_e           op;
    tgt_sel_e         tgt;
    scan_mode_e       scan;
    logic [ST_W-1:0]  st;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic h_end;
    logic hmatch;
    logic xmatch;
    logic hfound;
    logic own_eq_p;
    logic own_eq_a;
    logic held_full;
    logic lw_full;
    logic cw_full;
    logic l_end;
    logic c_end;
    logic ldrop;
    logic cdrop;
    logic cmatch;
    logic out_free;
    logic pend_v;
  } stat_t;

endpackage

// ===== hw/rtl/mclm_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mclm request and reply channels
// Valid/ready channels carrying lock requests and process replies.
// ----------------------------------------------------------------------------
interface mclm_req_if;
  logic                        valid;
  logic                        ready;
  logic [mclm_pkg::MODE_W-1:0] mode;
  logic [mclm_pkg::PROC_W-1:0] process;
  logic [mclm_pkg::KEY_W-1:0]  mutex_key;
  logic [mclm_pkg::KEY_W-1:0]  condition_key;
  modport source(output valid, mode, process, mutex_key, condition_key, input ready);
  modport sink(input valid, mode, process, mutex_key, condition_key, output ready);
endinterface

interface mclm_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [mclm_pkg::PROC_W-1:0] target_process;
  logic [mclm_pkg::ST_W-1:0]   status;
  logic                        last;
  modport source(output valid, target_process, status, last, input ready);
  modport sink(input valid, target_process, status, last, output ready);
endinterface

// ===== hw/rtl/mutex_condvar_lock_manager_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mutex_condvar_lock_manager_top
// Lock manager for mutexes and condition variables: request in, replies
// addressed to processes out.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  req_i    in   valid/ready   mode, process, mutex_key, condition_key
//  rsp_o    out  valid/ready   target_process, status, last
//
// one request at a time; every entry visited in the held, lock waiter
// and condition waiter tables takes a registered memory read, then a
// compare; each mutex released by exit and each waiter woken by
// broadcast adds a held or lock waiter pass of its own.
// reset empties all tables through their counts, no clearing pass.
// a stalled reply port holds the sequencer at its next reply.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mutex_condvar_lock_manager_top #(
  parameter int HELD_DEPTH = 32,
  parameter int PROC_SLOTS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mclm_req_if.sink          req_i,
  mclm_rsp_if.source        rsp_o
);

  mclm_pkg::cmd_t  cmd;
  mclm_pkg::stat_t stat;
  logic            in_ready;

  mclm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .stat_i     (stat),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  mclm_dp #(
    .HELD_DEPTH (HELD_DEPTH),
    .PROC_SLOTS (PROC_SLOTS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .req_mode_i          (req_i.mode),
    .req_process_i       (req_i.process),
    .req_mutex_key_i     (req_i.mutex_key),
    .req_condition_key_i (req_i.condition_key),
    .out_ready_i         (rsp_o.ready),
    .stat_o              (stat),
    .out_valid_o         (rsp_o.valid),
    .out_target_o        (rsp_o.target_process),
    .out_status_o        (rsp_o.status),
    .out_last_o          (rsp_o.last)
  );

  assign req_i.ready = in_ready;

  `MCLM_ASSERT(a_emit_room, (cmd.op == mclm_pkg::OP_EMIT) |-> stat.out_free)
  `MCLM_NEVER(a_idle_pending, req_i.ready && stat.pend_v)
  `MCLM_ASSERT(a_flush, cmd.op == mclm_pkg::OP_FLUSH && stat.pend_v |=> rsp_o.valid && rsp_o.last)

endmodule

// ===== hw/rtl/mclm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mclm_dp
// Held table, lock waiter and condition waiter memories with their counts,
// scan pointers, compare logic and the reply holding stage.
// ----------------------------------------------------------------------------
module mclm_dp #(
  parameter int HELD_DEPTH = 32,
  parameter int PROC_SLOTS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mclm_pkg::cmd_t              cmd_i,
  input  logic [mclm_pkg::MODE_W-1:0] req_mode_i,
  input  logic [mclm_pkg::PROC_W-1:0] req_process_i,
  input  logic [mclm_pkg::KEY_W-1:0]  req_mutex_key_i,
  input  logic [mclm_pkg::KEY_W-1:0]  req_condition_key_i,
  input  logic                        out_ready_i,
  output mclm_pkg::stat_t             stat_o,
  output logic                        out_valid_o,
  output logic [mclm_pkg::PROC_W-1:0] out_target_o,
  output logic [mclm_pkg::ST_W-1:0]   out_status_o,
  output logic                        out_last_o
);

  localparam int HIW = $clog2(HELD_DEPTH);
  localparam int HCW = $clog2(HELD_DEPTH + 1);
  localparam int LIW = $clog2(PROC_SLOTS);
  localparam int LCW = $clog2(PROC_SLOTS + 1);

  mclm_pkg::ent_t    held_mem [HELD_DEPTH];
  mclm_pkg::ent_t    lw_mem   [PROC_SLOTS];
  mclm_pkg::cw_ent_t cw_mem   [PROC_SLOTS];

  logic [mclm_pkg::MODE_W-1:0] mode_q;
  logic [mclm_pkg::PROC_W-1:0] p_q, aproc_q, gproc_q, howner_q;
  logic [mclm_pkg::KEY_W-1:0]  mkey_q, ckey_q, akey_q, rkey_q;
  logic [HIW-1:0]              hidx_q;
  logic [HCW-1:0]              hi_q, hc_q, hlast;
  logic [LCW-1:0]              lc_q, lr_q, lwp_q, cc_q, cr_q, cwp_q;
  logic                        hfound_q, ldrop_q, cdrop_q;
  mclm_pkg::scan_mode_e        lmode_q, cmode_q;
  mclm_pkg::ent_t              hrd_q, lrd_q;
  mclm_pkg::cw_ent_t           crd_q;
  logic                        pend_v_q, out_v_q, out_last_q;
  logic [mclm_pkg::PROC_W-1:0] pend_tgt_q, out_tgt_q, new_tgt;
  logic [mclm_pkg::ST_W-1:0]   pend_st_q, out_st_q;

  logic                        h_we, l_we, c_we;
  logic [HIW-1:0]              h_wa;
  logic [LIW-1:0]              l_wa, c_wa;
  mclm_pkg::ent_t              h_wd, l_wd;
  mclm_pkg::cw_ent_t           c_wd;
  logic                        lpred, cpred, hmatch, xmatch, load_out;

  assign hlast  = hc_q - HCW'(1);
  assign hmatch = (hrd_q.key == akey_q);
  assign xmatch = (hrd_q.own == p_q);
  assign load_out = ((cmd_i.op == mclm_pkg::OP_EMIT) || (cmd_i.op == mclm_pkg::OP_FLUSH))
                    && pend_v_q;

  always_comb begin
    case (lmode_q)
      mclm_pkg::SCAN_KEY_FIRST:  lpred = !ldrop_q && (lrd_q.key == rkey_q);
      mclm_pkg::SCAN_PROC_FIRST: lpred = !ldrop_q && (lrd_q.own == p_q);
      default:                   lpred = (lrd_q.own == p_q);
    endcase
    case (cmode_q)
      mclm_pkg::SCAN_PROC_FIRST: cpred = !cdrop_q && (crd_q.proc == p_q);
      default:                   cpred = (crd_q.proc == p_q);
    endcase
    case (cmd_i.tgt)
      mclm_pkg::TGT_ACQ:   new_tgt = aproc_q;
      mclm_pkg::TGT_GRANT: new_tgt = gproc_q;
      default:             new_tgt = p_q;
    endcase
  end

  // memory write port selection
  always_comb begin
    h_we = 1'b0;
    h_wa = hidx_q;
    h_wd = hrd_q;
    l_we = 1'b0;
    l_wa = lc_q[LIW-1:0];
    l_wd = '{key: akey_q, own: aproc_q};
    c_we = 1'b0;
    c_wa = cc_q[LIW-1:0];
    c_wd = '{cond: ckey_q, proc: p_q, mut: mkey_q};
    case (cmd_i.op)
      mclm_pkg::OP_H_MOVE: h_we = 1'b1;
      mclm_pkg::OP_H_APPEND: begin
        h_we = 1'b1;
        h_wa = hc_q[HIW-1:0];
        h_wd = '{key: akey_q, own: aproc_q};
      end
      mclm_pkg::OP_H_APPEND_G: begin
        h_we = 1'b1;
        h_wa = hc_q[HIW-1:0];
        h_wd = '{key: rkey_q, own: gproc_q};
      end
      mclm_pkg::OP_LW_APPEND: l_we = 1'b1;
      mclm_pkg::OP_LCHK: begin
        l_we = !lpred;
        l_wa = lwp_q[LIW-1:0];
        l_wd = lrd_q;
      end
      mclm_pkg::OP_CW_APPEND: c_we = 1'b1;
      mclm_pkg::OP_CCHK: begin
        c_we = !cpred;
        c_wa = cwp_q[LIW-1:0];
        c_wd = crd_q;
      end
      mclm_pkg::OP_CKEEP: begin
        c_we = 1'b1;
        c_wa = cwp_q[LIW-1:0];
        c_wd = crd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (h_we) held_mem[h_wa] <= h_wd;
    if (cmd_i.op == mclm_pkg::OP_HRD) hrd_q <= held_mem[hi_q[HIW-1:0]];
    else if (cmd_i.op == mclm_pkg::OP_HRD_LAST) hrd_q <= held_mem[hlast[HIW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (l_we) lw_mem[l_wa] <= l_wd;
    if (cmd_i.op == mclm_pkg::OP_LRD) lrd_q <= lw_mem[lr_q[LIW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) cw_mem[c_wa] <= c_wd;
    if (cmd_i.op == mclm_pkg::OP_CRD) crd_q <= cw_mem[cr_q[LIW-1:0]];
  end

  // counts, pointers and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q     <= '0;
      hi_q     <= '0;
      hfound_q <= 1'b0;
      lc_q     <= '0;
      lr_q     <= '0;
      lwp_q    <= '0;
      ldrop_q  <= 1'b0;
      lmode_q  <= mclm_pkg::SCAN_KEY_FIRST;
      cc_q     <= '0;
      cr_q     <= '0;
      cwp_q    <= '0;
      cdrop_q  <= 1'b0;
      cmode_q  <= mclm_pkg::SCAN_KEY_FIRST;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (load_out) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
      case (cmd_i.op)
        mclm_pkg::OP_HSCAN_INIT, mclm_pkg::OP_ALOAD_CW: begin
          hi_q     <= '0;
          hfound_q <= 1'b0;
        end
        mclm_pkg::OP_HCHK: begin
          if (hmatch) hfound_q <= 1'b1;
          else hi_q <= hi_q + HCW'(1);
        end
        mclm_pkg::OP_XCHK: if (!xmatch) hi_q <= hi_q + HCW'(1);
        mclm_pkg::OP_H_MOVE: hc_q <= hc_q - HCW'(1);
        mclm_pkg::OP_H_APPEND, mclm_pkg::OP_H_APPEND_G: hc_q <= hc_q + HCW'(1);
        mclm_pkg::OP_LW_APPEND: lc_q <= lc_q + LCW'(1);
        mclm_pkg::OP_LC_INIT: begin
          lr_q    <= '0;
          lwp_q   <= '0;
          ldrop_q <= 1'b0;
          lmode_q <= cmd_i.scan;
        end
        mclm_pkg::OP_LCHK: begin
          lr_q <= lr_q + LCW'(1);
          if (lpred) ldrop_q <= 1'b1;
          else lwp_q <= lwp_q + LCW'(1);
        end
        mclm_pkg::OP_LC_END: lc_q <= lwp_q;
        mclm_pkg::OP_CW_APPEND: cc_q <= cc_q + LCW'(1);
        mclm_pkg::OP_CC_INIT: begin
          cr_q    <= '0;
          cwp_q   <= '0;
          cdrop_q <= 1'b0;
          cmode_q <= cmd_i.scan;
        end
        mclm_pkg::OP_CCHK: begin
          cr_q <= cr_q + LCW'(1);
          if (cpred) cdrop_q <= 1'b1;
          else cwp_q <= cwp_q + LCW'(1);
        end
        mclm_pkg::OP_CKEEP: begin
          cr_q  <= cr_q + LCW'(1);
          cwp_q <= cwp_q + LCW'(1);
        end
        mclm_pkg::OP_CDROP: cr_q <= cr_q + LCW'(1);
        mclm_pkg::OP_CC_END: cc_q <= cwp_q;
        mclm_pkg::OP_EMIT: pend_v_q <= 1'b1;
        mclm_pkg::OP_FLUSH: pend_v_q <= 1'b0;
        default: ;
      endcase
    end
  end

  // request, working keys and reply payload
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_tgt_q  <= pend_tgt_q;
      out_st_q   <= pend_st_q;
      out_last_q <= (cmd_i.op == mclm_pkg::OP_FLUSH);
    end
    case (cmd_i.op)
      mclm_pkg::OP_CAPTURE: begin
        mode_q  <= req_mode_i;
        p_q     <= req_process_i;
        mkey_q  <= req_mutex_key_i;
        ckey_q  <= req_condition_key_i;
        akey_q  <= req_mutex_key_i;
        aproc_q <= req_process_i;
      end
      mclm_pkg::OP_ALOAD_CW: begin
        akey_q  <= crd_q.mut;
        aproc_q <= crd_q.proc;
      end
      mclm_pkg::OP_HCHK: begin
        if (hmatch) begin
          hidx_q   <= hi_q[HIW-1:0];
          howner_q <= hrd_q.own;
        end
      end
      mclm_pkg::OP_XCHK: if (xmatch) hidx_q <= hi_q[HIW-1:0];
      mclm_pkg::OP_REL_START: rkey_q <= hrd_q.key;
      mclm_pkg::OP_LCHK: if (lpred) gproc_q <= lrd_q.own;
      mclm_pkg::OP_EMIT: begin
        pend_tgt_q <= new_tgt;
        pend_st_q  <= cmd_i.st;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o.mode      = mode_q;
    stat_o.h_end     = (hi_q >= hc_q);
    stat_o.hmatch    = hmatch;
    stat_o.xmatch    = xmatch;
    stat_o.hfound    = hfound_q;
    stat_o.own_eq_p  = (howner_q == p_q);
    stat_o.own_eq_a  = (howner_q == aproc_q);
    stat_o.held_full = (hc_q >= HCW'(HELD_DEPTH));
    stat_o.lw_full   = (lc_q >= LCW'(PROC_SLOTS));
    stat_o.cw_full   = (cc_q >= LCW'(PROC_SLOTS));
    stat_o.l_end     = (lr_q >= lc_q);
    stat_o.c_end     = (cr_q >= cc_q);
    stat_o.ldrop     = ldrop_q;
    stat_o.cdrop     = cdrop_q;
    stat_o.cmatch    = (crd_q.cond == ckey_q);
    stat_o.out_free  = !out_v_q || out_ready_i;
    stat_o.pend_v    = pend_v_q;
  end

  assign out_valid_o  = out_v_q;
  assign out_target_o = out_tgt_q;
  assign out_status_o = out_st_q;
  assign out_last_o   = out_last_q;

endmodule

// ===== hw/rtl/mclm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mclm_ctrl
// Sequencer for lock, unlock, wait, broadcast, unpause and exit: walks the
// tables one entry at a time through datapath commands.
// ----------------------------------------------------------------------------
module mclm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  mclm_pkg::stat_t stat_i,
  output logic            in_ready_o,
  output mclm_pkg::cmd_t  cmd_o
);

  localparam int SW = 5;
  localparam logic [SW-1:0] S_IDLE     = 5'd0;
  localparam logic [SW-1:0] S_DISPATCH = 5'd1;
  localparam logic [SW-1:0] S_F_RD     = 5'd2;
  localparam logic [SW-1:0] S_F_CK     = 5'd3;
  localparam logic [SW-1:0] S_F_DONE   = 5'd4;
  localparam logic [SW-1:0] S_A_DEC    = 5'd5;
  localparam logic [SW-1:0] S_A_RET    = 5'd6;
  localparam logic [SW-1:0] S_R_START  = 5'd7;
  localparam logic [SW-1:0] S_R_LAST   = 5'd8;
  localparam logic [SW-1:0] S_R_MOVE   = 5'd9;
  localparam logic [SW-1:0] S_L_INIT   = 5'd10;
  localparam logic [SW-1:0] S_L_RD     = 5'd11;
  localparam logic [SW-1:0] S_L_CK     = 5'd12;
  localparam logic [SW-1:0] S_L_DONE   = 5'd13;
  localparam logic [SW-1:0] S_R_RET    = 5'd14;
  localparam logic [SW-1:0] S_C_RD     = 5'd15;
  localparam logic [SW-1:0] S_C_CK     = 5'd16;
  localparam logic [SW-1:0] S_C_DONE   = 5'd17;
  localparam logic [SW-1:0] S_X_RD     = 5'd18;
  localparam logic [SW-1:0] S_X_CK     = 5'd19;
  localparam logic [SW-1:0] S_EMIT     = 5'd20;
  localparam logic [SW-1:0] S_FLUSH    = 5'd21;

  logic [SW-1:0]             state_q, state_d, em_next_q, em_next_d;
  logic                      acq_q, acq_d, rel_q, rel_d, afail_q, afail_d;
  mclm_pkg::tgt_sel_e        em_tgt_q, em_tgt_d;
  logic [mclm_pkg::ST_W-1:0] em_st_q, em_st_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    em_next_d  = em_next_q;
    acq_d      = acq_q;
    rel_d      = rel_q;
    afail_d    = afail_q;
    em_tgt_d   = em_tgt_q;
    em_st_d    = em_st_q;
    cmd_o.op   = mclm_pkg::OP_NONE;
    cmd_o.tgt  = mclm_pkg::TGT_REQ;
    cmd_o.scan = mclm_pkg::SCAN_KEY_FIRST;
    cmd_o.st   = mclm_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = mclm_pkg::OP_CAPTURE;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.mode)
          mclm_pkg::MODE_LOCK: begin
            cmd_o.op = mclm_pkg::OP_HSCAN_INIT;
            acq_d    = 1'b1;
            state_d  = S_F_RD;
          end
          mclm_pkg::MODE_UNLOCK, mclm_pkg::MODE_WAIT: begin
            cmd_o.op = mclm_pkg::OP_HSCAN_INIT;
            acq_d    = 1'b0;
            state_d  = S_F_RD;
          end
          mclm_pkg::MODE_BCAST: begin
            cmd_o.op   = mclm_pkg::OP_CC_INIT;
            cmd_o.scan = mclm_pkg::SCAN_PROC_ALL;
            state_d    = S_C_RD;
          end
          mclm_pkg::MODE_UNPAUSE, mclm_pkg::MODE_EXIT: begin
            em_tgt_d  = mclm_pkg::TGT_REQ;
            em_st_d   = mclm_pkg::ST_OK;
            em_next_d = S_L_INIT;
            state_d   = S_EMIT;
          end
          default: state_d = S_FLUSH;
        endcase
      end
      S_F_RD: begin
        if (stat_i.h_end) begin
          state_d = S_F_DONE;
        end else begin
          cmd_o.op = mclm_pkg::OP_HRD;
          state_d  = S_F_CK;
        end
      end
      S_F_CK: begin
        cmd_o.op = mclm_pkg::OP_HCHK;
        state_d  = stat_i.hmatch ? S_F_DONE : S_F_RD;
      end
      S_F_DONE: begin
        if (acq_q) begin
          state_d = S_A_DEC;
        end else if (!stat_i.hfound || !stat_i.own_eq_p ||
                     ((stat_i.mode == mclm_pkg::MODE_WAIT) && stat_i.cw_full)) begin
          em_tgt_d  = mclm_pkg::TGT_REQ;
          em_st_d   = (stat_i.mode == mclm_pkg::MODE_WAIT) ? mclm_pkg::ST_BAD_WAIT
                                                           : mclm_pkg::ST_BAD_UNLOCK;
          em_next_d = S_FLUSH;
          state_d   = S_EMIT;
        end else begin
          state_d = S_R_START;
        end
      end
      S_A_DEC: begin
        afail_d = 1'b0;
        state_d = S_A_RET;
        if (stat_i.hfound) begin
          if (stat_i.own_eq_a) begin
            em_tgt_d  = mclm_pkg::TGT_ACQ;
            em_st_d   = mclm_pkg::ST_OK;
            em_next_d = S_A_RET;
            state_d   = S_EMIT;
          end else if (!stat_i.lw_full) begin
            cmd_o.op = mclm_pkg::OP_LW_APPEND;
          end else begin
            afail_d = 1'b1;
          end
        end else if (!stat_i.held_full) begin
          cmd_o.op  = mclm_pkg::OP_H_APPEND;
          em_tgt_d  = mclm_pkg::TGT_ACQ;
          em_st_d   = mclm_pkg::ST_OK;
          em_next_d = S_A_RET;
          state_d   = S_EMIT;
        end else begin
          afail_d = 1'b1;
        end
      end
      S_A_RET: begin
        acq_d = 1'b0;
        if (stat_i.mode == mclm_pkg::MODE_BCAST) begin
          cmd_o.op = afail_q ? mclm_pkg::OP_CKEEP : mclm_pkg::OP_CDROP;
          state_d  = S_C_RD;
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_R_START: begin
        cmd_o.op = mclm_pkg::OP_REL_START;
        rel_d    = 1'b1;
        state_d  = S_R_LAST;
      end
      S_R_LAST: begin
        cmd_o.op = mclm_pkg::OP_HRD_LAST;
        state_d  = S_R_MOVE;
      end
      S_R_MOVE: begin
        // last entry fills the freed slot
        cmd_o.op = mclm_pkg::OP_H_MOVE;
        state_d  = S_L_INIT;
      end
      S_L_INIT: begin
        cmd_o.op = mclm_pkg::OP_LC_INIT;
        if (rel_q) cmd_o.scan = mclm_pkg::SCAN_KEY_FIRST;
        else if (stat_i.mode == mclm_pkg::MODE_UNPAUSE) cmd_o.scan = mclm_pkg::SCAN_PROC_FIRST;
        else cmd_o.scan = mclm_pkg::SCAN_PROC_ALL;
        state_d = S_L_RD;
      end
      S_L_RD: begin
        if (stat_i.l_end) begin
          cmd_o.op = mclm_pkg::OP_LC_END;
          state_d  = S_L_DONE;
        end else begin
          cmd_o.op = mclm_pkg::OP_LRD;
          state_d  = S_L_CK;
        end
      end
      S_L_CK: begin
        cmd_o.op = mclm_pkg::OP_LCHK;
        state_d  = S_L_RD;
      end
      S_L_DONE: begin
        if (rel_q) begin
          state_d = S_R_RET;
          if (stat_i.ldrop) begin
            // oldest waiter takes the mutex
            cmd_o.op  = mclm_pkg::OP_H_APPEND_G;
            em_tgt_d  = mclm_pkg::TGT_GRANT;
            em_st_d   = mclm_pkg::ST_OK;
            em_next_d = S_R_RET;
            state_d   = S_EMIT;
          end
        end else if (stat_i.mode == mclm_pkg::MODE_UNPAUSE) begin
          if (stat_i.ldrop) begin
            em_tgt_d  = mclm_pkg::TGT_REQ;
            em_st_d   = mclm_pkg::ST_OK;
            em_next_d = S_FLUSH;
            state_d   = S_EMIT;
          end else begin
            cmd_o.op   = mclm_pkg::OP_CC_INIT;
            cmd_o.scan = mclm_pkg::SCAN_PROC_FIRST;
            state_d    = S_C_RD;
          end
        end else begin
          cmd_o.op   = mclm_pkg::OP_CC_INIT;
          cmd_o.scan = mclm_pkg::SCAN_PROC_ALL;
          state_d    = S_C_RD;
        end
      end
      S_R_RET: begin
        rel_d = 1'b0;
        case (stat_i.mode)
          mclm_pkg::MODE_UNLOCK: begin
            em_tgt_d  = mclm_pkg::TGT_REQ;
            em_st_d   = mclm_pkg::ST_OK;
            em_next_d = S_FLUSH;
            state_d   = S_EMIT;
          end
          mclm_pkg::MODE_WAIT: begin
            cmd_o.op = mclm_pkg::OP_CW_APPEND;
            state_d  = S_FLUSH;
          end
          default: state_d = S_X_RD;
        endcase
      end
      S_C_RD: begin
        if (stat_i.c_end) begin
          cmd_o.op = mclm_pkg::OP_CC_END;
          state_d  = S_C_DONE;
        end else begin
          cmd_o.op = mclm_pkg::OP_CRD;
          state_d  = S_C_CK;
        end
      end
      S_C_CK: begin
        if (stat_i.mode == mclm_pkg::MODE_BCAST) begin
          if (stat_i.cmatch) begin
            cmd_o.op = mclm_pkg::OP_ALOAD_CW;
            acq_d    = 1'b1;
            state_d  = S_F_RD;
          end else begin
            cmd_o.op = mclm_pkg::OP_CKEEP;
            state_d  = S_C_RD;
          end
        end else begin
          cmd_o.op = mclm_pkg::OP_CCHK;
          state_d  = S_C_RD;
        end
      end
      S_C_DONE: begin
        case (stat_i.mode)
          mclm_pkg::MODE_BCAST: begin
            em_tgt_d  = mclm_pkg::TGT_REQ;
            em_st_d   = mclm_pkg::ST_OK;
            em_next_d = S_FLUSH;
            state_d   = S_EMIT;
          end
          mclm_pkg::MODE_UNPAUSE: begin
            state_d = S_FLUSH;
            if (stat_i.cdrop) begin
              em_tgt_d  = mclm_pkg::TGT_REQ;
              em_st_d   = mclm_pkg::ST_OK;
              em_next_d = S_FLUSH;
              state_d   = S_EMIT;
            end
          end
          default: begin
            cmd_o.op = mclm_pkg::OP_HSCAN_INIT;
            state_d  = S_X_RD;
          end
        endcase
      end
      S_X_RD: begin
        if (stat_i.h_end) begin
          state_d = S_FLUSH;
        end else begin
          cmd_o.op = mclm_pkg::OP_HRD;
          state_d  = S_X_CK;
        end
      end
      S_X_CK: begin
        // on a match the index stays, the moved-in entry is checked next
        cmd_o.op = mclm_pkg::OP_XCHK;
        state_d  = stat_i.xmatch ? S_R_START : S_X_RD;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op  = mclm_pkg::OP_EMIT;
          cmd_o.tgt = em_tgt_q;
          cmd_o.st  = em_st_q;
          state_d   = em_next_q;
        end
      end
      S_FLUSH: begin
        if (!stat_i.pend_v || stat_i.out_free) begin
          cmd_o.op = mclm_pkg::OP_FLUSH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      em_next_q <= S_IDLE;
      acq_q     <= 1'b0;
      rel_q     <= 1'b0;
      afail_q   <= 1'b0;
      em_tgt_q  <= mclm_pkg::TGT_REQ;
      em_st_q   <= mclm_pkg::ST_OK;
    end else begin
      state_q   <= state_d;
      em_next_q <= em_next_d;
      acq_q     <= acq_d;
      rel_q     <= rel_d;
      afail_q   <= afail_d;
      em_tgt_q  <= em_tgt_d;
      em_st_q   <= em_st_d;
    end
  end

endmodule
